/* sv/ath_pkg.sv */
// Shared constants and types for the averaged hysteresis thermostat.
`default_nettype none

package ath_pkg;

    // Sizing of the sample path.
    localparam int MAX_WINDOW  = 16;
    localparam int SAMPLE_BITS = 12;

    // Register field widths.
    localparam int TGT_W  = 12;
    localparam int HYST_W = 12;
    localparam int WIN_W  = 5;
    localparam int CFG_W  = 12;
    localparam int IDX_W  = 2;

    // Derived widths.
    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + PTR_W + 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int STEP_W = $clog2(MAG_W);
    localparam int CMP_W  = ((SAMPLE_BITS > TGT_W) ? SAMPLE_BITS : TGT_W) + 2;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_TARGET = 2'd0,
        REG_HYST   = 2'd1,
        REG_WINDOW = 2'd2
    } t_cfg_idx;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_POST = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage : ath_pkg

`default_nettype wire

/* sv/averaged_hysteresis_thermostat_unit.sv */
// Averaged hysteresis thermostat: sample ring, running sum, serial divider, comparator.
// Sequence: a valid reading runs 16 bit-serial restoring-divide steps of the running sum
//   by the sample count on the shared subtractor, then the compare and the output load;
//   an invalid one goes straight to the output load. A new reading is held off until the
//   last one reaches the output register. Reset: synchronous, active low; clears all state
//   but the ring, divider, result flags and output data (window length back to 8).
`default_nettype none

module averaged_hysteresis_thermostat_unit
    import ath_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // Reading channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_reading,
    input  wire logic                   i_reading_valid,

    // Result channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [SAMPLE_BITS-1:0]      o_average_temp,
    output logic                        o_temp_high,
    output logic                        o_crossing,
    output logic                        o_crossed_upward,
    output logic                        o_window_ready,
    output logic                        o_sample_taken,

    // Configuration write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state                  r_state, n_state;

    // History: ring (no reset), pointer, fill count, running sum, average.
    logic [SAMPLE_BITS-1:0]  r_ring [MAX_WINDOW];
    logic [PTR_W-1:0]        r_ptr, n_ptr;
    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [SAMPLE_BITS-1:0]  r_avg, n_avg;
    logic                    r_above, n_above;

    // Registers.
    logic [TGT_W-1:0]        r_target, n_target;
    logic [HYST_W-1:0]       r_hyst, n_hyst;
    logic [CNT_W-1:0]        r_win, n_win;

    // Divider working set: quotient/dividend shift register, partial remainder.
    logic [MAG_W-1:0]        r_quo, n_quo;
    logic [CNT_W-1:0]        r_rem, n_rem;
    logic [STEP_W-1:0]       r_step, n_step;
    logic                    r_neg, n_neg;

    // Result flags waiting for the output register.
    logic                    r_cross, n_cross;
    logic                    r_up, n_up;
    logic                    r_taken, n_taken;

    // Output register.
    logic                    r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0]  r_out_avg, n_out_avg;
    logic                    r_out_above, n_out_above;
    logic                    r_out_cross, n_out_cross;
    logic                    r_out_up, n_out_up;
    logic                    r_out_ready, n_out_ready;
    logic                    r_out_taken, n_out_taken;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_beat, cfg_beat, out_free;

    // Hold readings off while a register write is offered so the two never share an edge.
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_beat     = i_in_valid && !o_in_stall;
    assign cfg_beat    = i_cfg_valid && o_cfg_ready;
    // Output register can take a new beat when empty or being drained now.
    assign out_free    = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Datapath pieces
    // ------------------------------------------------------------------
    logic                    full_now;
    logic signed [SUM_W-1:0] old_ext, new_ext, upd_sum;
    logic [CNT_W-1:0]        ptr_inc, win_clamp;
    logic [MAG_W-1:0]        upd_mag;

    // Shared subtractor of the divider.
    logic [CNT_W:0]          div_shift;
    logic [CNT_W+1:0]        div_diff;
    logic                    div_borrow;

    logic [SAMPLE_BITS-1:0]  quo_low, div_avg;
    logic signed [CMP_W-1:0] avg_cmp, tgt_cmp, low_cmp;

    assign full_now = (r_count >= r_win);

    // Drop the oldest sample once the ring is full, add the new one.
    assign old_ext = full_now ? SUM_W'($signed(r_ring[r_ptr])) : '0;
    assign new_ext = SUM_W'($signed(i_reading));
    assign upd_sum = r_sum - old_ext + new_ext;
    assign upd_mag = upd_sum[SUM_W-1] ? MAG_W'(-upd_sum) : MAG_W'(upd_sum);

    assign ptr_inc = CNT_W'(r_ptr) + CNT_W'(1);

    // Window length is forced into 1..MAX_WINDOW.
    always_comb begin
        priority if (i_cfg_data[WIN_W-1:0] == '0) begin
            win_clamp = CNT_W'(1);
        end else if (32'(i_cfg_data[WIN_W-1:0]) > 32'(MAX_WINDOW)) begin
            win_clamp = CNT_W'(MAX_WINDOW);
        end else begin
            win_clamp = CNT_W'(i_cfg_data[WIN_W-1:0]);
        end
    end

    // One restoring step: shift in the next dividend bit, try subtracting.
    assign div_shift  = {r_rem, r_quo[MAG_W-1]};
    assign div_diff   = {1'b0, div_shift} - {2'b00, r_count};
    assign div_borrow = div_diff[CNT_W+1];

    // Quotient magnitude fits the sample width; apply sign (truncates toward zero).
    assign quo_low = r_quo[SAMPLE_BITS-1:0];
    assign div_avg = r_neg ? (~quo_low + SAMPLE_BITS'(1)) : quo_low;

    // Comparator at full width so a deep band never wraps.
    assign avg_cmp = CMP_W'($signed(div_avg));
    assign tgt_cmp = CMP_W'($signed(r_target));
    assign low_cmp = tgt_cmp - $signed({{(CMP_W-HYST_W){1'b0}}, r_hyst});

    // ------------------------------------------------------------------
    // Sequencer and next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_count     = r_count;
        n_sum       = r_sum;
        n_avg       = r_avg;
        n_above     = r_above;
        n_target    = r_target;
        n_hyst      = r_hyst;
        n_win       = r_win;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_step      = r_step;
        n_neg       = r_neg;
        n_cross     = r_cross;
        n_up        = r_up;
        n_taken     = r_taken;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_avg   = r_out_avg;
        n_out_above = r_out_above;
        n_out_cross = r_out_cross;
        n_out_up    = r_out_up;
        n_out_ready = r_out_ready;
        n_out_taken = r_out_taken;

        // Register writes arrive only while idle.
        if (cfg_beat) begin
            unique case (i_cfg_index)
                REG_TARGET: n_target = i_cfg_data[TGT_W-1:0];
                REG_HYST:   n_hyst   = i_cfg_data[HYST_W-1:0];
                REG_WINDOW: begin
                    // Drop history, keep comparator state.
                    n_win   = win_clamp;
                    n_ptr   = '0;
                    n_count = '0;
                    n_sum   = '0;
                    n_avg   = '0;
                end
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_cross = 1'b0;
                    n_up    = 1'b0;
                    n_taken = i_reading_valid;
                    if (i_reading_valid) begin
                        // Advance the ring and load the divider.
                        n_sum   = upd_sum;
                        n_ptr   = (ptr_inc >= r_win) ? '0 : PTR_W'(ptr_inc);
                        n_count = full_now ? r_count : r_count + CNT_W'(1);
                        n_quo   = upd_mag;
                        n_neg   = upd_sum[SUM_W-1];
                        n_rem   = '0;
                        n_step  = STEP_W'(MAG_W - 1);
                        n_state = S_DIV;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_DIV: begin
                n_quo = {r_quo[MAG_W-2:0], !div_borrow};
                n_rem = div_borrow ? div_shift[CNT_W-1:0] : div_diff[CNT_W-1:0];
                if (r_step == '0) begin
                    n_state = S_POST;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_POST: begin
                n_avg = div_avg;
                if (full_now) begin
                    if (!r_above && (avg_cmp >= tgt_cmp)) begin
                        n_above = 1'b1;
                        n_cross = 1'b1;
                        n_up    = 1'b1;
                    end else if (r_above && (avg_cmp <= low_cmp)) begin
                        n_above = 1'b0;
                        n_cross = 1'b1;
                    end
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // Hold until the output register frees up.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_avg;
                    n_out_above = r_above;
                    n_out_cross = r_cross;
                    n_out_up    = r_up;
                    n_out_ready = full_now;
                    n_out_taken = r_taken;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_avg       <= '0;
            r_above     <= 1'b0;
            r_target    <= '0;
            r_hyst      <= '0;
            r_win       <= CNT_W'((8 > MAX_WINDOW) ? MAX_WINDOW : 8);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_avg       <= n_avg;
            r_above     <= n_above;
            r_target    <= n_target;
            r_hyst      <= n_hyst;
            r_win       <= n_win;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && i_reading_valid) begin
            r_ring[r_ptr] <= i_reading;
        end
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_step      <= n_step;
        r_neg       <= n_neg;
        r_cross     <= n_cross;
        r_up        <= n_up;
        r_taken     <= n_taken;
        r_out_avg   <= n_out_avg;
        r_out_above <= n_out_above;
        r_out_cross <= n_out_cross;
        r_out_up    <= n_out_up;
        r_out_ready <= n_out_ready;
        r_out_taken <= n_out_taken;
    end

    assign o_out_valid      = r_out_valid;
    assign o_average_temp   = r_out_avg;
    assign o_temp_high      = r_out_above;
    assign o_crossing       = r_out_cross;
    assign o_crossed_upward = r_out_up;
    assign o_window_ready   = r_out_ready;
    assign o_sample_taken   = r_out_taken;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_win)
        else $error("fill count exceeds window length");

    a_ptr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_ptr) < r_win)
        else $error("ring pointer outside window");

    a_cross_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_crossing) |-> (o_window_ready && o_sample_taken))
        else $error("crossing reported without a full window and a stored sample");

    a_cross_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_crossing) |-> (o_temp_high == o_crossed_upward))
        else $error("crossing direction disagrees with comparator state");

    a_up_implies_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_crossed_upward) |-> o_crossing)
        else $error("upward flag without a crossing");

    a_div_to_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == '0) |=> (r_state == S_POST))
        else $error("divider did not hand over after its last step");

endmodule : averaged_hysteresis_thermostat_unit

`default_nettype wire
